@@ hdl/ewas_pkg.sv @@
// Shared types and constants for the energy window activity segmenter.
// Item structs for both channels, register indexes and fixed field widths.
// No dependencies.
package ewas_pkg;

  localparam int SAMPLE_W = 16;
  localparam int INDEX_OUT_W = 32;
  localparam int WLEN_W = 16;
  localparam int THR_W = 31;
  localparam int ENERGY_W = 47;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENERGY_THRESHOLD = 2'd1;

  localparam logic [WLEN_W-1:0] WINDOW_LEN_RESET = 16'd160;
  localparam logic [THR_W-1:0] ENERGY_THRESHOLD_RESET = 31'd10737;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last_sample;
  } in_t;

  typedef struct packed {
    logic [INDEX_OUT_W-1:0] seg_start;
    logic [INDEX_OUT_W-1:0] seg_end;
    logic                   seg_valid;
    logic                   stream_done;
  } out_t;

  typedef struct packed {
    logic emit;
    out_t item;
  } core_res_t;

endpackage

@@ hdl/ewas_seg_core.sv @@
// Window energy accumulation, activity decision and segment tracking.
// One squared sample per step; holds all stream state.
// Depends on ewas_pkg.
module ewas_seg_core #(
  parameter int INDEX_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           step,
  input  logic [ewas_pkg::ENERGY_W-1:0]  sq,
  input  logic                           last,
  input  logic [ewas_pkg::WLEN_W-1:0]    win_len,
  input  logic [ewas_pkg::THR_W-1:0]     thr,
  output ewas_pkg::core_res_t            res
);

  localparam int EW = ewas_pkg::ENERGY_W;
  localparam int CW = ewas_pkg::WLEN_W;
  localparam int OW = ewas_pkg::INDEX_OUT_W;

  logic [INDEX_BITS-1:0] pos_r, pos_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [EW-1:0]         sum_r, sum_nxt;
  logic                  in_seg_r, in_seg_nxt;
  logic [INDEX_BITS-1:0] open_r, open_nxt;
  logic [EW-1:0]         prod_r, prod_nxt;

  logic [CW-1:0]         len_eff, cnt_inc, cnt_base, cnt_base_inc;
  logic [INDEX_BITS-1:0] pos_inc, cnt_ext, wstart, open_upd;
  logic [EW:0]           sum_wide;
  logic [EW-1:0]         sum_new;
  logic                  close, active, seg_upd, seg_win, seg_any;
  logic [INDEX_BITS-1:0] s_start, s_end;

  always_comb begin
    len_eff  = (win_len == '0) ? CW'(1) : win_len;
    cnt_inc  = (cnt_r == '1) ? cnt_r : cnt_r + CW'(1);
    pos_inc  = (pos_r == '1) ? pos_r : pos_r + INDEX_BITS'(1);
    sum_wide = {1'b0, sum_r} + {1'b0, sq};
    sum_new  = sum_wide[EW] ? '1 : sum_wide[EW-1:0];
    close    = (cnt_inc >= len_eff) || last;
    cnt_ext  = INDEX_BITS'(cnt_inc);
    wstart   = (pos_inc >= cnt_ext) ? pos_inc - cnt_ext : '0;
    // prod_r already holds threshold times the post-increment count
    active   = sum_new >= prod_r;
    seg_win  = close && !active && in_seg_r;
    seg_upd  = close ? active : in_seg_r;
    open_upd = (close && active && !in_seg_r) ? wstart : open_r;
    seg_any  = seg_win || (last && seg_upd);

    if (seg_win) begin
      s_start = open_r;
      s_end   = wstart;
    end else if (last && seg_upd) begin
      s_start = open_upd;
      s_end   = pos_inc;
    end else begin
      s_start = '0;
      s_end   = '0;
    end

    res.emit             = last || seg_win;
    res.item.seg_start   = OW'(s_start);
    res.item.seg_end     = OW'(s_end);
    res.item.seg_valid   = seg_any;
    res.item.stream_done = last;

    pos_nxt    = pos_r;
    cnt_nxt    = cnt_r;
    sum_nxt    = sum_r;
    in_seg_nxt = in_seg_r;
    open_nxt   = open_r;
    if (step) begin
      if (last) begin
        pos_nxt    = '0;
        cnt_nxt    = '0;
        sum_nxt    = '0;
        in_seg_nxt = 1'b0;
        open_nxt   = '0;
      end else begin
        pos_nxt    = pos_inc;
        cnt_nxt    = close ? '0 : cnt_inc;
        sum_nxt    = close ? '0 : sum_new;
        in_seg_nxt = seg_upd;
        open_nxt   = open_upd;
      end
    end

    // look one sample ahead: threshold times the count the next step will see
    cnt_base     = step ? cnt_nxt : cnt_r;
    cnt_base_inc = (cnt_base == '1) ? cnt_base : cnt_base + CW'(1);
    prod_nxt     = EW'(thr) * EW'(cnt_base_inc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      cnt_r    <= '0;
      sum_r    <= '0;
      in_seg_r <= 1'b0;
      open_r   <= '0;
    end else begin
      pos_r    <= pos_nxt;
      cnt_r    <= cnt_nxt;
      sum_r    <= sum_nxt;
      in_seg_r <= in_seg_nxt;
      open_r   <= open_nxt;
    end
    prod_r <= prod_nxt;
  end

endmodule

@@ hdl/energy_window_activity_segmenter_unit.sv @@
// Top level of the energy window activity segmenter.
// Input register, squaring stage, segment core and result register.
// Depends on ewas_pkg and ewas_seg_core.
//
// Usage:
//   Input channel (in_valid, in_stall, in_data) carries one audio sample per
//   item plus a last-sample flag. Result channel (out_valid, out_stall,
//   out_data) carries a segment start/end pair when a segment closes, and
//   always one item for the last sample of a stream, with stream_done set.
//   Configuration (cfg_valid, cfg_ready, cfg_index, cfg_data) writes the
//   window length (index 0) and the mean-square threshold (index 1); write
//   only while no item is in flight. cfg_ready is always high.
// Timing:
//   Three pipeline registers: input, square, result. out_valid rises when
//   an emitting item reaches the result register. One item per cycle unless a
//   result is held stalled; window accumulate and compare are combinational.
// Reset:
//   Synchronous, active low. Clears stream state and loads register defaults
//   (window length 160, threshold 10737). State also clears after each last
//   sample.
// Backpressure:
//   A stalled result holds in the output register and no item leaves the
//   square stage meanwhile; the input and square stages fill before in_stall
//   rises.
module energy_window_activity_segmenter_unit #(
  parameter int INDEX_BITS  = 32,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  ewas_pkg::in_t                     in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output ewas_pkg::out_t                    out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ewas_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ewas_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int EW   = ewas_pkg::ENERGY_W;
  localparam int SQ_W = 2 * SAMPLE_BITS;

  logic [ewas_pkg::WLEN_W-1:0] win_len_r, win_len_nxt;
  logic [ewas_pkg::THR_W-1:0]  thr_r, thr_nxt;

  logic           s1_v_r, s1_v_nxt;
  ewas_pkg::in_t  s1_r;
  logic           s2_v_r, s2_v_nxt;
  logic [EW-1:0]  sq_r;
  logic           s2_last_r;

  logic           out_v_r, out_v_nxt;
  ewas_pkg::out_t out_r;

  logic                   out_free, s2_ready, s2_go, s1_go, in_take;
  logic [SAMPLE_BITS-1:0] raw, mag;
  logic [SQ_W-1:0]        sq_full;
  ewas_pkg::core_res_t    res;

  assign cfg_ready = 1'b1;

  always_comb begin
    win_len_nxt = win_len_r;
    thr_nxt     = thr_r;
    if (cfg_valid) begin
      case (cfg_index)
        ewas_pkg::REG_WINDOW_LEN:       win_len_nxt = cfg_data[ewas_pkg::WLEN_W-1:0];
        ewas_pkg::REG_ENERGY_THRESHOLD: thr_nxt = cfg_data[ewas_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  // elastic handshake: a stage loads when empty or when its item moves on
  assign out_free = !out_v_r || !out_stall;
  assign s2_go    = s2_v_r && out_free;
  assign s2_ready = !s2_v_r || out_free;
  assign s1_go    = s1_v_r && s2_ready;
  assign in_stall = s1_v_r && !s2_ready;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_v_nxt  = in_take ? 1'b1 : (s1_go ? 1'b0 : s1_v_r);
    s2_v_nxt  = s1_go ? 1'b1 : (s2_go ? 1'b0 : s2_v_r);
    out_v_nxt = s2_go ? res.emit : (out_stall ? out_v_r : 1'b0);
  end

  // magnitude of the low SAMPLE_BITS bits, taken as two's complement
  always_comb begin
    raw     = SAMPLE_BITS'($unsigned(s1_r.sample));
    mag     = raw[SAMPLE_BITS-1] ? (~raw + SAMPLE_BITS'(1)) : raw;
    sq_full = SQ_W'(mag) * SQ_W'(mag);
  end

  ewas_seg_core #(
    .INDEX_BITS(INDEX_BITS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (s2_go),
    .sq      (sq_r),
    .last    (s2_last_r),
    .win_len (win_len_r),
    .thr     (thr_r),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_len_r <= ewas_pkg::WINDOW_LEN_RESET;
      thr_r     <= ewas_pkg::ENERGY_THRESHOLD_RESET;
      s1_v_r    <= 1'b0;
      s2_v_r    <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      win_len_r <= win_len_nxt;
      thr_r     <= thr_nxt;
      s1_v_r    <= s1_v_nxt;
      s2_v_r    <= s2_v_nxt;
      out_v_r   <= out_v_nxt;
    end
    if (in_take) begin
      s1_r <= in_data;
    end
    if (s1_go) begin
      sq_r      <= EW'(sq_full);
      s2_last_r <= s1_r.last_sample;
    end
    if (s2_go) begin
      out_r <= res.item;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  // a result that does not end the stream always carries a segment
  a_mid_result_has_seg: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_r.stream_done) |-> out_r.seg_valid)
    else $error("result without segment before stream end");

  // an empty result carries zero indices
  a_empty_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_r.seg_valid) |-> (out_r.seg_start == '0 && out_r.seg_end == '0))
    else $error("empty result with non-zero indices");

  // an empty input register never stalls the sender
  a_empty_input_takes: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_v_r |-> !in_stall)
    else $error("stall raised with empty input register");

  // a result that has not been taken stays in place
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_stall) |=> (out_v_r && $stable(out_r)))
    else $error("stalled result lost or changed");

endmodule
